// ----- src/satp_pkg.sv -----
// ============================================================================
// Storage atom token parser package
// Shared types, codes and the token classification function.
// ============================================================================
`default_nettype none

package satp_pkg;

    // Default width of the payload length counter
    localparam int SATP_LENGTH_BITS = 24;

    // Token kinds
    typedef enum logic [1:0] {
        KIND_UINT  = 2'd0,
        KIND_SINT  = 2'd1,
        KIND_BYTES = 2'd2,
        KIND_CTRL  = 2'd3
    } satp_kind_t;

    // Integer value status
    typedef enum logic [1:0] {
        VST_VALID  = 2'd0,
        VST_SIGNED = 2'd1,
        VST_UNSUP  = 2'd2
    } satp_status_t;

    // Classification of a completed token
    typedef struct packed {
        satp_kind_t   kind;
        satp_status_t status;
        logic [63:0]  value;
    } satp_class_t;

    // One result item
    typedef struct packed {
        logic [7:0]   echo_byte;
        logic         byte_role;
        logic         token_start;
        logic         token_end;
        logic [15:0]  token_index;
        satp_kind_t   token_kind;
        logic [7:0]   control_code;
        logic [63:0]  uint_value;
        satp_status_t value_status;
        logic         truncated;
    } satp_result_t;

    // Classify a token from its first byte and accumulated payload
    function automatic satp_class_t satp_classify(input logic [7:0] f,
                                                  input logic [63:0] acc);
        satp_class_t c;
        c.kind   = KIND_UINT;
        c.status = VST_VALID;
        c.value  = 64'd0;
        if (!f[7]) begin
            // Tiny atom
            if (f[6]) begin
                c.kind   = KIND_SINT;
                c.status = VST_SIGNED;
            end else begin
                c.value = {58'd0, f[5:0]};
            end
        end else if (!f[6]) begin
            // Short atom
            if (f[5]) begin
                c.kind   = KIND_BYTES;
                c.status = VST_UNSUP;
            end else if (f[4]) begin
                c.kind   = KIND_SINT;
                c.status = VST_SIGNED;
            end else begin
                c.value = acc;
            end
        end else if (!f[5]) begin
            // Medium atom
            c.kind   = f[4] ? KIND_BYTES : (f[3] ? KIND_SINT : KIND_UINT);
            c.status = VST_UNSUP;
        end else if (!f[4]) begin
            // Long atom
            c.kind   = f[1] ? KIND_BYTES : (f[0] ? KIND_SINT : KIND_UINT);
            c.status = VST_UNSUP;
        end else begin
            // Control token
            c.kind   = KIND_CTRL;
            c.status = VST_UNSUP;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/satp_parser.sv -----
// ============================================================================
// Storage atom token parser: parse state and per-byte step
// Holds the atom parse state and computes the result for the current byte.
// ============================================================================
`default_nettype none

module satp_parser #(
    parameter int LENGTH_BITS = satp_pkg::SATP_LENGTH_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic [7:0]          data_byte,
    input  wire logic                packet_end,
    output satp_pkg::satp_result_t   res
);
    import satp_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRST   = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    localparam logic [LENGTH_BITS-1:0] LEN_ALL_ONES = '1;

    phase_t                  phase_reg, phase_next;
    logic [7:0]              first_reg, first_next;
    logic [1:0]              hdr_left_reg, hdr_left_next;
    logic [LENGTH_BITS-1:0]  pay_left_reg, pay_left_next;
    logic [63:0]             acc_reg, acc_next;
    logic [15:0]             count_reg, count_next;

    logic                    role;
    logic                    start;
    logic                    done;
    logic                    trunc;
    logic [7:0]              code;
    phase_t                  phase_eff;
    satp_class_t             cls;

    // Step the parser on the current byte
    always_comb
    begin
        phase_next    = phase_reg;
        first_next    = first_reg;
        hdr_left_next = hdr_left_reg;
        pay_left_next = pay_left_reg;
        acc_next      = acc_reg;
        count_next    = count_reg;
        role          = 1'b0;
        start         = 1'b0;
        done          = 1'b0;
        trunc         = 1'b0;

        // Fall back to a first header byte when nothing is left to take
        case (phase_reg)
            PH_FIRST:   phase_eff = PH_FIRST;
            PH_HEADER:  phase_eff = (hdr_left_reg == 2'd0) ? PH_FIRST : PH_HEADER;
            PH_PAYLOAD: phase_eff = (pay_left_reg == '0) ? PH_FIRST : PH_PAYLOAD;
            default:    phase_eff = PH_FIRST;
        endcase

        case (phase_eff)
            PH_HEADER:
            begin
                if (|pay_left_reg[LENGTH_BITS-1 -: 8])
                    pay_left_next = LEN_ALL_ONES;
                else
                    pay_left_next = {pay_left_reg[LENGTH_BITS-9:0], data_byte};
                hdr_left_next = hdr_left_reg - 2'd1;
                phase_next    = PH_HEADER;
                if (hdr_left_next == 2'd0) begin
                    if (pay_left_next == '0)
                        done = 1'b1;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                role          = 1'b1;
                phase_next    = PH_PAYLOAD;
                acc_next      = {acc_reg[55:0], data_byte};
                pay_left_next = pay_left_reg - LENGTH_BITS'(1);
                if (pay_left_next == '0)
                    done = 1'b1;
            end
            default:
            begin
                start         = 1'b1;
                first_next    = data_byte;
                acc_next      = 64'd0;
                pay_left_next = '0;
                hdr_left_next = 2'd0;
                phase_next    = PH_FIRST;
                if (!data_byte[7]) begin
                    done = 1'b1;
                end else if (!data_byte[6]) begin
                    pay_left_next = LENGTH_BITS'(data_byte[3:0]);
                    if (data_byte[3:0] == 4'd0)
                        done = 1'b1;
                    else
                        phase_next = PH_PAYLOAD;
                end else if (!data_byte[5]) begin
                    hdr_left_next = 2'd1;
                    pay_left_next = LENGTH_BITS'({data_byte[2:0], 8'h00});
                    phase_next    = PH_HEADER;
                end else if (!data_byte[4]) begin
                    hdr_left_next = 2'd3;
                    phase_next    = PH_HEADER;
                end else begin
                    done = 1'b1;
                end
            end
        endcase

        // Classify from the token state before any packet end clears it
        cls  = satp_classify(first_next, acc_next);
        code = first_next;

        // Close the token
        if (done) begin
            if (count_reg != 16'hffff)
                count_next = count_reg + 16'd1;
            phase_next = PH_FIRST;
        end

        // Drop all state at the end of a packet
        if (packet_end) begin
            trunc         = !done;
            phase_next    = PH_FIRST;
            first_next    = 8'd0;
            hdr_left_next = 2'd0;
            pay_left_next = '0;
            acc_next      = 64'd0;
            count_next    = 16'd0;
        end

        res.echo_byte    = data_byte;
        res.byte_role    = role;
        res.token_start  = start;
        res.token_end    = done;
        res.token_index  = count_reg;
        res.token_kind   = done ? cls.kind : KIND_UINT;
        res.control_code = done ? code : 8'd0;
        res.uint_value   = done ? cls.value : 64'd0;
        res.value_status = done ? cls.status : VST_VALID;
        res.truncated    = trunc;
    end

    // Hold parse state between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= PH_FIRST;
            first_reg    <= 8'd0;
            hdr_left_reg <= 2'd0;
            pay_left_reg <= '0;
            acc_reg      <= 64'd0;
            count_reg    <= 16'd0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            first_reg    <= first_next;
            hdr_left_reg <= hdr_left_next;
            pay_left_reg <= pay_left_next;
            acc_reg      <= acc_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/storage_atom_token_parser_core.sv -----
// ============================================================================
// Storage atom token parser core
// Splits a response subpacket payload into atoms and control tokens.
// ============================================================================
// One item is one payload byte; every byte gives exactly one result item that
// echoes it with its role and token index, and on a token's last byte also
// carries the kind, first byte, unsigned value and status. The core takes one
// byte per clock unless the result side stalls: a byte is captured in an input
// register, the parse step runs between that register and the result register,
// and the parse state updates and the result item is shown as the byte moves
// into the result register; a stall on the result side holds one byte in each
// register before in_ready drops. Parse state returns to reset after a byte
// marked packet_end, so token indices restart in every subpacket.
`default_nettype none

module storage_atom_token_parser_core #(
    parameter int LENGTH_BITS = satp_pkg::SATP_LENGTH_BITS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   data_byte,
    input  wire logic         packet_end,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        echo_byte,
    output logic              byte_role,
    output logic              token_start,
    output logic              token_end,
    output logic [15:0]       token_index,
    output logic [1:0]        token_kind,
    output logic [7:0]        control_code,
    output logic [63:0]       uint_value,
    output logic [1:0]        value_status,
    output logic              truncated
);
    import satp_pkg::*;

    logic          in_v_reg;
    logic [7:0]    byte_reg;
    logic          pend_reg;
    logic          out_v_reg;
    satp_result_t  res_reg;
    satp_result_t  step_res;
    logic          advance;

    // Move the held byte on when the result register is free
    assign advance  = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready = !in_v_reg || advance;

    // Hold the accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_v_reg <= 1'b0;
        end else if (in_ready) begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            byte_reg <= data_byte;
            pend_reg <= packet_end;
        end
    end

    satp_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .data_byte  (byte_reg),
        .packet_end (pend_reg),
        .res        (step_res)
    );

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_v_reg <= 1'b0;
        end else if (advance) begin
            out_v_reg <= 1'b1;
        end else if (out_ready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            res_reg <= step_res;
        end
    end

    assign out_valid    = out_v_reg;
    assign echo_byte    = res_reg.echo_byte;
    assign byte_role    = res_reg.byte_role;
    assign token_start  = res_reg.token_start;
    assign token_end    = res_reg.token_end;
    assign token_index  = res_reg.token_index;
    assign token_kind   = res_reg.token_kind;
    assign control_code = res_reg.control_code;
    assign uint_value   = res_reg.uint_value;
    assign value_status = res_reg.value_status;
    assign truncated    = res_reg.truncated;

endmodule

`default_nettype wire
